>>> sv/tss_pkg.sv
// Package with widths and the pipeline payload types for the triangle scanline span block.
`timescale 1ns / 1ps
package tss_pkg;
   localparam int COORD_BITS = 10;
   localparam int COLOR_BITS = 32;
   localparam int PROD_BITS = 2 * COORD_BITS + 1;
   localparam int QUOT_BITS = COORD_BITS + 1;
   localparam int DIV_STEPS = COORD_BITS;
   localparam int PIPE_STAGES = DIV_STEPS + 3;
   localparam int SPAN_Y_BITS = COORD_BITS + 1;
   localparam int IN_BITS = 7 * COORD_BITS + COLOR_BITS;
   localparam int IN_BYTES = (IN_BITS + 7) / 8;
   localparam int OUT_BITS = SPAN_Y_BITS + 2 * COORD_BITS + COLOR_BITS;
   localparam int OUT_BYTES = (OUT_BITS + 7) / 8;

   typedef logic [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] mag;
      logic                  neg;
   } sdiff_type;

   // One long division in flight: remainder, partial quotient and remaining dividend bits.
   typedef struct packed {
      logic [PROD_BITS-1:0]  num;
      logic [COORD_BITS-1:0] den;
      logic [COORD_BITS:0]   rem;
      logic                  neg;
      coord_type             base;
   } div_type;

   typedef struct packed {
      logic                   ok;
      logic [SPAN_Y_BITS-1:0] y;
      logic [COLOR_BITS-1:0]  color;
   } side_type;
endpackage

>>> sv/triangle_scanline_span_top.sv
// Top level of the triangle scanline span block: sort, multiply, long division pipeline.
//
//  channel | direction | tdata (low bit first)                            | tuser
//  req_    | in        | x_a y_a x_b y_b x_c y_c row fill_color           | none
//  rsp_    | out       | span_y span_start span_end span_color            | span_valid
//
// One transfer may enter every cycle while rsp_ is not stalled. There are DIV_STEPS + 3
// register stages: sort, multiply, one restoring divider stage per quotient bit, and the
// output register.
// Reset clears only the stage valid bits; no memory needs clearing.
// A stall on rsp_ freezes every stage at once, so nothing is lost or repeated.
`timescale 1ns / 1ps
module triangle_scanline_span_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // x_a, y_a, x_b, y_b, x_c, y_c, row, fill_color, zero fill
   input  logic [tss_pkg::IN_BYTES*8-1:0]  req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // span_y, span_start, span_end, span_color, zero fill
   output logic [tss_pkg::OUT_BYTES*8-1:0] rsp_tdata,
   // span_valid
   output logic                            rsp_tuser
);
   import tss_pkg::*;

   logic advance;
   logic [PIPE_STAGES-1:0] valid_ff, valid_in;

   // Stage 1: sort and differences.
   coord_type x0, y0, x1, y1, x2, y2, rw, t;
   logic flat_w;
   always_comb begin
      t  = '0;
      x0 = req_tdata[0*COORD_BITS +: COORD_BITS];
      y0 = req_tdata[1*COORD_BITS +: COORD_BITS];
      x1 = req_tdata[2*COORD_BITS +: COORD_BITS];
      y1 = req_tdata[3*COORD_BITS +: COORD_BITS];
      x2 = req_tdata[4*COORD_BITS +: COORD_BITS];
      y2 = req_tdata[5*COORD_BITS +: COORD_BITS];
      rw = req_tdata[6*COORD_BITS +: COORD_BITS];
      flat_w = (y0 == y1) && (y0 == y2);
      if (y0 > y1) begin
         t = x0; x0 = x1; x1 = t; t = y0; y0 = y1; y1 = t;
      end
      if (y0 > y2) begin
         t = x0; x0 = x2; x2 = t; t = y0; y0 = y2; y2 = t;
      end
      if (y1 > y2) begin
         t = x1; x1 = x2; x2 = t; t = y1; y1 = y2; y2 = t;
      end
   end

   coord_type s1_x0_ff, s1_x1_ff, s1_x2_ff, s1_row_ff, s1_tot_ff, s1_lh_ff, s1_uh_ff;
   coord_type s1_y0_ff;
   logic      s1_flat_ff;
   logic [COLOR_BITS-1:0] s1_col_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_x0_ff   <= x0;
         s1_x1_ff   <= x1;
         s1_x2_ff   <= x2;
         s1_y0_ff   <= y0;
         s1_row_ff  <= rw;
         s1_tot_ff  <= y2 - y0;
         s1_lh_ff   <= y1 - y0;
         s1_uh_ff   <= y2 - y1;
         s1_flat_ff <= flat_w;
         s1_col_ff  <= req_tdata[7*COORD_BITS +: COLOR_BITS];
      end
   end

   // Stage 2: multiplications, setting up both divisions.
   logic upper_w;
   sdiff_type da_w, db_w;
   coord_type nb_w;
   logic [PROD_BITS-1:0] pa_w, pb_w;
   div_type a2_in, b2_in;
   side_type sd2_in;
   always_comb begin
      upper_w = (s1_row_ff > s1_lh_ff) || (s1_lh_ff == '0);
      da_w.neg = s1_x2_ff < s1_x0_ff;
      da_w.mag = da_w.neg ? s1_x0_ff - s1_x2_ff : s1_x2_ff - s1_x0_ff;
      if (upper_w) begin
         db_w.neg = s1_x2_ff < s1_x1_ff;
         db_w.mag = db_w.neg ? s1_x1_ff - s1_x2_ff : s1_x2_ff - s1_x1_ff;
         nb_w = s1_row_ff - s1_lh_ff;
      end else begin
         db_w.neg = s1_x1_ff < s1_x0_ff;
         db_w.mag = db_w.neg ? s1_x0_ff - s1_x1_ff : s1_x1_ff - s1_x0_ff;
         nb_w = s1_row_ff;
      end
      pa_w = PROD_BITS'(da_w.mag) * PROD_BITS'(s1_row_ff);
      pb_w = PROD_BITS'(db_w.mag) * PROD_BITS'(nb_w);
      a2_in = '{num: pa_w, den: s1_tot_ff, rem: '0, neg: da_w.neg, base: s1_x0_ff};
      b2_in = '{num: pb_w, den: (upper_w ? s1_uh_ff : s1_lh_ff), rem: '0,
                neg: db_w.neg, base: (upper_w ? s1_x1_ff : s1_x0_ff)};
      sd2_in.ok = !s1_flat_ff && (s1_row_ff < s1_tot_ff);
      sd2_in.y = SPAN_Y_BITS'(s1_y0_ff) + SPAN_Y_BITS'(s1_row_ff);
      sd2_in.color = s1_col_ff;
   end

   // Division stages, one quotient bit each; the quotient shifts into num.
   div_type  da_ff [DIV_STEPS+1];
   div_type  db_ff [DIV_STEPS+1];
   side_type sd_ff [DIV_STEPS+1];

   function automatic div_type div_step(div_type d);
      div_type r;
      logic [COORD_BITS+1:0] tr;
      r = d;
      tr = {d.rem, d.num[PROD_BITS-1]};
      r.num = {d.num[PROD_BITS-2:0], 1'b0};
      if (tr >= {2'b00, d.den}) begin
         tr = tr - {2'b00, d.den};
         r.num[0] = 1'b1;
      end
      r.rem = tr[COORD_BITS:0];
      return r;
   endfunction

   // The quotient fits COORD_BITS bits, so the top product bits are below the divisor
   // and seed the remainder directly.
   div_type a_seed, b_seed;
   always_comb begin
      a_seed = a2_in;
      b_seed = b2_in;
      a_seed.rem = a2_in.num[PROD_BITS-1 -: QUOT_BITS];
      a_seed.num = {a2_in.num[PROD_BITS-QUOT_BITS-1:0], QUOT_BITS'(0)};
      b_seed.rem = b2_in.num[PROD_BITS-1 -: QUOT_BITS];
      b_seed.num = {b2_in.num[PROD_BITS-QUOT_BITS-1:0], QUOT_BITS'(0)};
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         da_ff[0] <= a_seed;
         db_ff[0] <= b_seed;
         sd_ff[0] <= sd2_in;
         for (int k = 1; k <= DIV_STEPS; k++) begin
            da_ff[k] <= div_step(da_ff[k-1]);
            db_ff[k] <= div_step(db_ff[k-1]);
            sd_ff[k] <= sd_ff[k-1];
         end
      end
   end

   // Final stage: apply sign, add base, order the ends; zero data if no span.
   coord_type qa, qb, av, bv;
   logic [OUT_BITS-1:0] od_in, od_ff;
   logic ou_in, ou_ff;
   always_comb begin
      qa = da_ff[DIV_STEPS].num[COORD_BITS-1:0];
      qb = db_ff[DIV_STEPS].num[COORD_BITS-1:0];
      av = da_ff[DIV_STEPS].neg ? da_ff[DIV_STEPS].base - qa : da_ff[DIV_STEPS].base + qa;
      bv = db_ff[DIV_STEPS].neg ? db_ff[DIV_STEPS].base - qb : db_ff[DIV_STEPS].base + qb;
      if (!sd_ff[DIV_STEPS].ok) begin
         od_in = '0;
         ou_in = 1'b0;
      end else begin
         od_in = (av > bv) ?
                 {sd_ff[DIV_STEPS].color, av, bv, sd_ff[DIV_STEPS].y} :
                 {sd_ff[DIV_STEPS].color, bv, av, sd_ff[DIV_STEPS].y};
         ou_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         od_ff <= od_in;
         ou_ff <= ou_in;
      end
   end

   always_comb begin
      valid_in = {valid_ff[PIPE_STAGES-2:0], req_tvalid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   assign advance    = rsp_tready || !valid_ff[PIPE_STAGES-1];
   assign req_tready = advance;
   assign rsp_tvalid = valid_ff[PIPE_STAGES-1];
   assign rsp_tdata  = {{(OUT_BYTES*8-OUT_BITS){1'b0}}, od_ff};
   assign rsp_tuser  = ou_ff;

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(valid_ff))
      else $error("pipeline moved during stall");
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == '0))
      else $error("invalid span carries data");
   a_span_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[SPAN_Y_BITS+COORD_BITS +: COORD_BITS] >=
                      rsp_tdata[SPAN_Y_BITS +: COORD_BITS]))
      else $error("span ends out of order");
endmodule
